/* rtl/uklq_pkg.sv */
package uklq_pkg;

  localparam int unsigned QueueDepthDefault = 8;
  localparam int unsigned KeyBytesDefault   = 8;

  localparam logic [1:0] OP_ENQUEUE = 2'd0;
  localparam logic [1:0] OP_DEQUEUE = 2'd1;
  localparam logic [1:0] OP_PEEK    = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_DUP   = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] key_in;
  } in_item_t;

  typedef struct packed {
    logic [63:0] key_out;
    logic [1:0]  status;
    logic [3:0]  occupancy;
  } out_item_t;

endpackage

/* rtl/unique_key_linear_queue.sv */
// Unique-key linear queue.
// Input channel (in_valid_i/in_ready_o, in_data_i) carries one item: an
// opcode (enqueue, dequeue, peek) and a key. Output channel (out_valid_o/
// out_ready_i, out_data_o) returns exactly one result item per input item:
// head key, status (ok, full, duplicate, empty) and occupancy afterwards.
// Items are handled one at a time; in_ready_o is high only while idle.
// Enqueue into a non-empty, non-full queue scans the held entries through
// the single read port of the entry store, one entry per cycle against one
// 64-bit comparator, and stops at the first match or after the last entry.
// Full, empty, first enqueue and unused opcodes go straight to the result
// register; dequeue and peek first take one store read of the head entry.
// The block is ready again as soon as the result is loaded.
// The result sits in an output register; if the receiver stalls, the block
// still accepts and works on the next item, and waits only to load its
// result until the held one is taken.
// Reset (rst_ni low, asynchronous) empties the queue and drops any pending
// result. Entry store contents are not cleared; the pointers keep stale
// slots from ever being used.
module unique_key_linear_queue
  import uklq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned KEY_BYTES   = KeyBytesDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam logic [PW-1:0] DepthP = PW'(QUEUE_DEPTH);
  localparam logic [63:0] KeyMask = {64{1'b1}} >> (64 - 8 * KEY_BYTES);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_HEAD,
    S_RESP
  } state_e;

  state_e      state_q;
  logic [PW-1:0] head_q, tail_q, scan_q;
  logic [1:0]  op_q;
  logic [63:0] key_q;
  logic        cmp_vld_q;
  logic [63:0] rd_q;
  logic [63:0] res_key_q;
  logic [1:0]  res_st_q;
  logic        out_valid_q;
  out_item_t   out_q;

  logic [63:0] mem_q [QUEUE_DEPTH];

  logic          in_fire;
  logic [63:0]   key_m;
  logic          issue, hit, scan_miss;
  logic          first_wr;
  logic          mem_we, mem_re;
  logic [IW-1:0] mem_wa, mem_ra;
  logic [63:0]   mem_wd;
  logic [PW-1:0] occ_w;
  logic [PW-1:0] head_nx;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign key_m       = in_data_i.key_in & KeyMask;
  assign issue       = (scan_q < tail_q);
  assign hit         = cmp_vld_q && (rd_q == key_q);
  assign scan_miss   = !issue && !hit;
  assign first_wr    = (in_data_i.opcode == OP_ENQUEUE) && (tail_q < DepthP)
                       && (head_q == tail_q);
  assign occ_w       = tail_q - head_q;
  assign head_nx     = head_q + PW'(1);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = tail_q[IW-1:0];
    mem_wd = key_q;
    mem_ra = head_q[IW-1:0];
    case (state_q)
      S_IDLE: begin
        mem_we = in_fire && first_wr;
        mem_wd = key_m;
        mem_re = 1'b1;
      end
      S_SCAN: begin
        mem_we = scan_miss;
        mem_re = issue;
        mem_ra = scan_q[IW-1:0];
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rd_q <= mem_q[mem_ra];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      scan_q      <= '0;
      op_q        <= OP_ENQUEUE;
      key_q       <= '0;
      cmp_vld_q   <= 1'b0;
      res_key_q   <= '0;
      res_st_q    <= ST_OK;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            op_q      <= in_data_i.opcode;
            key_q     <= key_m;
            res_key_q <= '0;
            res_st_q  <= ST_OK;
            cmp_vld_q <= 1'b0;
            scan_q    <= head_q;
            state_q   <= S_RESP;
            case (in_data_i.opcode)
              OP_ENQUEUE: begin
                if (tail_q >= DepthP) begin
                  res_st_q <= ST_FULL;
                end else if (first_wr) begin
                  tail_q <= tail_q + PW'(1);
                end else begin
                  state_q <= S_SCAN;
                end
              end
              OP_DEQUEUE, OP_PEEK: begin
                if (head_q >= tail_q) begin
                  res_st_q <= ST_EMPTY;
                end else begin
                  state_q <= S_HEAD;
                end
              end
              default: begin
                res_st_q <= ST_OK;
              end
            endcase
          end
        end
        S_SCAN: begin
          cmp_vld_q <= issue;
          if (issue) begin
            scan_q <= scan_q + PW'(1);
          end
          if (hit) begin
            res_st_q <= ST_DUP;
            state_q  <= S_RESP;
          end else if (scan_miss) begin
            tail_q  <= tail_q + PW'(1);
            state_q <= S_RESP;
          end
        end
        S_HEAD: begin
          res_key_q <= rd_q;
          if (op_q == OP_DEQUEUE) begin
            if (head_nx == tail_q) begin
              head_q <= '0;
              tail_q <= '0;
            end else begin
              head_q <= head_nx;
            end
          end
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q     <= 1'b1;
            out_q.key_out   <= res_key_q;
            out_q.status    <= res_st_q;
            out_q.occupancy <= 4'(occ_w);
            state_q         <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  a_ptr_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_q <= tail_q)
    else $error("head pointer beyond tail pointer");

  a_tail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= DepthP)
    else $error("tail pointer beyond depth");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o)
    else $error("ready again straight after an accepted item");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status == ST_EMPTY) |-> out_data_o.occupancy == 4'd0)
    else $error("empty status with non-zero occupancy");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import uklq_pkg::*;

  localparam int unsigned Depth       = QueueDepthDefault;
  localparam int unsigned KeyBytes    = KeyBytesDefault;
  localparam logic [63:0] KeyMask     = (KeyBytes >= 8) ? '1 : ((64'd1 << (KeyBytes * 8)) - 64'd1);
  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned RandomItems = 400;
  localparam int unsigned StallLimit  = 2000;

  typedef struct {
    logic [1:0]  op;
    logic [63:0] key;
    bit          fixed;
    out_item_t   want;
  } stim_row_t;

  logic      clk_i;
  logic      rst_ni    = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  logic [63:0] slots [Depth];
  int unsigned head_idx = 0;
  int unsigned tail_idx = 0;

  out_item_t   pending_results [$];
  stim_row_t   directed_rows [$];
  out_item_t   head_want;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned burst_left     = 0;
  int unsigned stall_left     = 0;
  int unsigned stall_mode     = 0;

  unique_key_linear_queue #(
    .QUEUE_DEPTH(Depth),
    .KEY_BYTES  (KeyBytes)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic out_item_t queue_step(logic [1:0] op, logic [63:0] key_raw);
    out_item_t   res;
    logic [63:0] key;
    bit          held;
    key  = key_raw & KeyMask;
    res  = '0;
    held = 1'b0;
    res.status = ST_OK;
    if (op == OP_ENQUEUE) begin
      if (tail_idx >= Depth) begin
        res.status = ST_FULL;
      end else begin
        for (int unsigned i = head_idx; i < tail_idx; i++)
          if (slots[i] == key) held = 1'b1;
        if (held) begin
          res.status = ST_DUP;
        end else begin
          slots[tail_idx] = key;
          tail_idx++;
        end
      end
    end else if (op == OP_DEQUEUE || op == OP_PEEK) begin
      if (head_idx >= tail_idx) begin
        res.status = ST_EMPTY;
      end else begin
        res.key_out = slots[head_idx];
        if (op == OP_DEQUEUE) begin
          head_idx++;
          if (head_idx == tail_idx) begin
            head_idx = 0;
            tail_idx = 0;
          end
        end
      end
    end
    res.occupancy = 4'(tail_idx - head_idx);
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s: got %h, expected %h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_row(logic [1:0] op, logic [63:0] key, bit fixed,
                         logic [63:0] kout, logic [1:0] st, logic [3:0] occ);
    stim_row_t r;
    r.op    = op;
    r.key   = key;
    r.fixed = fixed;
    r.want  = '{key_out: kout, status: st, occupancy: occ};
    directed_rows.push_back(r);
  endtask

  // leaves valid high when the burst goes on
  task automatic send_item(logic [1:0] op, logic [63:0] key, bit fixed, out_item_t want);
    out_item_t predicted;
    in_valid <= 1'b1;
    in_data  <= '{opcode: op, key_in: key};
    do @(posedge clk_i); while (!in_ready);
    predicted = queue_step(op, key);
    pending_results.push_back(fixed ? want : predicted);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
    end
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      stall_left = $urandom_range(16, 80);
    end
    stall_left--;
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      default: out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result item with nothing pending", out_data.key_out, '0);
        end else begin
          head_want = pending_results.pop_front();
          if (out_data.key_out !== head_want.key_out)
            report_mismatch("key_out", out_data.key_out, head_want.key_out);
          if (out_data.status !== head_want.status)
            report_mismatch("status", 64'(out_data.status), 64'(head_want.status));
          if (out_data.occupancy !== head_want.occupancy)
            report_mismatch("occupancy", 64'(out_data.occupancy), 64'(head_want.occupancy));
        end
      end
      if (idle_cycles >= StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("testbench: FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0]  op;
    logic [63:0] key;
    int unsigned pick, roll, enq_limit, deq_limit, phase_left;
    bit          filling;
    phase_left = 0;
    filling    = 1'b0;

    add_row(OP_PEEK,    '1,   1, '0, ST_EMPTY, 4'd0);
    add_row(OP_DEQUEUE, '0,   1, '0, ST_EMPTY, 4'd0);
    add_row(OP_UNUSED,  '1,   1, '0, ST_OK,    4'd0);
    add_row(OP_ENQUEUE, '0,   1, '0, ST_OK,    4'd1);
    add_row(OP_ENQUEUE, '1,   1, '0, ST_OK,    4'd2);
    add_row(OP_ENQUEUE, '0,   1, '0, ST_DUP,   4'd2);
    add_row(OP_PEEK,    '1,   1, '0, ST_OK,    4'd2);
    add_row(OP_ENQUEUE, 64'h5555_5555_5555_5555, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'hAAAA_AAAA_AAAA_AAAA, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'h8000_0000_0000_0000, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'h0000_0000_0000_0001, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'h0123_4567_89AB_CDEF, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'hFEDC_BA98_7654_3210, 0, '0, ST_OK, 4'd0);
    // full wins over duplicate, and freed head slots are not reused
    add_row(OP_ENQUEUE, 64'h7, 1, '0, ST_FULL, 4'd8);
    add_row(OP_ENQUEUE, '1,    1, '0, ST_FULL, 4'd8);
    add_row(OP_DEQUEUE, '1,    1, '0, ST_OK,   4'd7);
    add_row(OP_ENQUEUE, 64'h7, 1, '0, ST_FULL, 4'd7);
    add_row(OP_UNUSED,  '0,    1, '0, ST_OK,   4'd7);
    repeat (7) add_row(OP_DEQUEUE, 64'h0F0F_0F0F_0F0F_0F0F, 0, '0, ST_OK, 4'd0);
    add_row(OP_ENQUEUE, 64'h7, 1, '0, ST_OK, 4'd1);

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i])
      send_item(directed_rows[i].op, directed_rows[i].key, directed_rows[i].fixed,
                directed_rows[i].want);
    wait_all_results();

    for (int n = 0; n < RandomItems; n++) begin
      if (n == RandomItems / 2) wait_all_results();
      if (phase_left == 0) begin
        filling    = !filling;
        phase_left = $urandom_range(8, 40);
      end
      phase_left--;
      enq_limit = filling ? 70 : 30;
      deq_limit = enq_limit + (100 - enq_limit) * 2 / 3;
      pick = $urandom_range(0, 99);
      key  = {$urandom, $urandom};
      if (pick < 3) begin
        op = OP_UNUSED;
      end else if (pick < enq_limit) begin
        op   = OP_ENQUEUE;
        roll = $urandom_range(0, 9);
        if (roll < 3 && tail_idx > head_idx)
          key = slots[$urandom_range(head_idx, tail_idx - 1)];
        else if (roll < 5)
          key = {32'd0, $urandom_range(0, 7)};
      end else if (pick < deq_limit) begin
        op = OP_DEQUEUE;
      end else begin
        op = OP_PEEK;
      end
      send_item(op, key, 1'b0, '0);
    end

    wait_all_results();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/uklq_pkg.sv
rtl/unique_key_linear_queue.sv
sim/testbench.sv
